>>> rtl/bpdo_pkg.sv
// Shared types and constants for the buffer pool with drop-oldest allocation.
`timescale 1ns / 1ps
`default_nettype none

package bpdo_pkg;

  localparam int unsigned DEF_MAX_BUFFERS = 16;
  localparam int unsigned HANDLE_W        = 4;
  localparam int unsigned CFG_W           = 5;
  localparam int unsigned CNT_OUT_W       = 5;
  localparam int unsigned IN_TDATA_W      = 8;
  localparam int unsigned OUT_TDATA_W     = 24;
  localparam int unsigned RESET_POOL      = 16;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_STORE   = 2'd1,
    FUNC_LOAD    = 2'd2,
    FUNC_RELEASE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/buffer_pool_drop_oldest_top.sv
// Top level of the buffer pool with drop-oldest allocation.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Each request on the s_axis channel carries an operation (allocate, store,
// load, release) and a handle. Every request produces exactly one result on
// the m_axis channel: a handle, its valid flag, the took-oldest flag, a status
// and the queue and free-list counts after the operation.
// In the accept state a request reads the free stack and the work queue
// memories into registers; in the execute state it updates pointers, writes
// memory and loads the result register. A new request is not taken until the
// previous one leaves the execute state, set by the registered memory read.
// A new request is accepted while the previous result still waits; if the
// receiver stalls, the update of that new request waits until the result
// register drains, and no further request is taken meanwhile.
// After reset the pool holds 16 handles (or MAX_BUFFERS if smaller) on the
// free list and the queue is empty. Writing pool_size through cfg_we_i refills
// the free list and empties the queue; write it only when idle.

module buffer_pool_drop_oldest_top #(
  parameter int unsigned MAX_BUFFERS = bpdo_pkg::DEF_MAX_BUFFERS
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [1:0] func, [5:2] handle, [7:6] zero
  input  wire [bpdo_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // [3:0] out_handle, [4] handle_valid, [5] took_oldest, [7:6] status,
  // [12:8] queued_count, [17:13] free_count_out, [23:18] zero
  output logic [bpdo_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  wire                                 cfg_we_i,
  input  wire [bpdo_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import bpdo_pkg::*;

  cmd_t                 cmd;
  logic [HANDLE_W-1:0]  out_handle;
  logic                 handle_valid;
  logic                 took_oldest;
  logic [1:0]           status;
  logic [CNT_OUT_W-1:0] queued_count;
  logic [CNT_OUT_W-1:0] free_count;

  bpdo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  bpdo_dp #(
    .MAX_BUFFERS (MAX_BUFFERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_func_i      (s_axis_tdata_i[1:0]),
    .in_handle_i    (s_axis_tdata_i[5:2]),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_handle_o   (out_handle),
    .handle_valid_o (handle_valid),
    .took_oldest_o  (took_oldest),
    .status_o       (status),
    .queued_count_o (queued_count),
    .free_count_o   (free_count)
  );

  assign m_axis_tdata_o = {6'd0, free_count, queued_count, status,
                           took_oldest, handle_valid, out_handle};

endmodule

`default_nettype wire

>>> rtl/bpdo_ctrl.sv
// Controller: request sequencing and the output valid register.
`timescale 1ns / 1ps
`default_nettype none

module bpdo_ctrl (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output bpdo_pkg::cmd_t cmd_o
);
  import bpdo_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        // The result register must be free or draining this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/bpdo_dp.sv
// Datapath: free stack, work queue, pointers, counts and the result register.
`timescale 1ns / 1ps
`default_nettype none

module bpdo_dp #(
  parameter int unsigned MAX_BUFFERS = bpdo_pkg::DEF_MAX_BUFFERS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  bpdo_pkg::cmd_t                    cmd_i,
  input  wire [1:0]                         in_func_i,
  input  wire [bpdo_pkg::HANDLE_W-1:0]      in_handle_i,
  input  wire                               cfg_we_i,
  input  wire [bpdo_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic [bpdo_pkg::HANDLE_W-1:0]     out_handle_o,
  output logic                              handle_valid_o,
  output logic                              took_oldest_o,
  output logic [1:0]                        status_o,
  output logic [bpdo_pkg::CNT_OUT_W-1:0]    queued_count_o,
  output logic [bpdo_pkg::CNT_OUT_W-1:0]    free_count_o
);
  import bpdo_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_BUFFERS);
  localparam int unsigned CW  = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned SW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned IW  = (AW > HANDLE_W) ? AW : HANDLE_W;
  localparam int unsigned RST_POOL = (MAX_BUFFERS < RESET_POOL) ? MAX_BUFFERS : RESET_POOL;

  logic [HANDLE_W-1:0] stack_mem [MAX_BUFFERS];
  logic [HANDLE_W-1:0] queue_mem [MAX_BUFFERS];
  logic [HANDLE_W-1:0] stack_rd_q, queue_rd_q;

  func_e               func_q;
  logic [HANDLE_W-1:0] handle_q;

  logic [CW-1:0] fc_q, fc_d, qc_q, qc_d, low_q, low_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;

  logic [CW-1:0]       fc_dec;
  logic [AW-1:0]       top_idx;
  logic [IW-1:0]       top_ext;
  logic [HANDLE_W-1:0] stack_val;
  logic [AW-1:0]       head_inc, tail_inc;
  logic                stack_we, queue_we;
  logic [HANDLE_W-1:0] oh_d;
  logic                valid_d, oldest_d;
  status_e             status_d;
  logic [SW-1:0]       cfg_ext, pool_sat, qc_wide, fc_wide;
  logic [CW-1:0]       pool_val;

  assign fc_dec  = fc_q - CW'(1);
  assign top_idx = fc_dec[AW-1:0];
  assign top_ext = IW'(top_idx);
  // Entries below the lowest stack depth seen since the last refill have not been
  // written since then; their value is taken as the low bits of their own index.
  assign stack_val = (fc_dec < low_q) ? top_ext[HANDLE_W-1:0] : stack_rd_q;

  assign head_inc = (head_q == AW'(MAX_BUFFERS - 1)) ? '0 : head_q + AW'(1);
  assign tail_inc = (tail_q == AW'(MAX_BUFFERS - 1)) ? '0 : tail_q + AW'(1);

  assign cfg_ext  = SW'(cfg_wdata_i);
  assign pool_sat = (cfg_ext == '0) ? SW'(1) :
                    ((cfg_ext > SW'(MAX_BUFFERS)) ? SW'(MAX_BUFFERS) : cfg_ext);
  assign pool_val = pool_sat[CW-1:0];

  always_comb begin
    fc_d     = fc_q;
    qc_d     = qc_q;
    low_d    = low_q;
    head_d   = head_q;
    tail_d   = tail_q;
    stack_we = 1'b0;
    queue_we = 1'b0;
    oh_d     = '0;
    valid_d  = 1'b0;
    oldest_d = 1'b0;
    status_d = ST_OK;
    unique case (func_q)
      FUNC_ALLOC: begin
        if (fc_q != '0) begin
          fc_d    = fc_dec;
          oh_d    = stack_val;
          valid_d = 1'b1;
          if (fc_dec < low_q) begin
            low_d = fc_dec;
          end
        end else if (qc_q != '0) begin
          qc_d     = qc_q - CW'(1);
          head_d   = head_inc;
          oh_d     = queue_rd_q;
          valid_d  = 1'b1;
          oldest_d = 1'b1;
        end else begin
          status_d = ST_EMPTY;
        end
      end
      FUNC_STORE: begin
        if (qc_q == CW'(MAX_BUFFERS)) begin
          status_d = ST_OVERFLOW;
        end else begin
          queue_we = 1'b1;
          tail_d   = tail_inc;
          qc_d     = qc_q + CW'(1);
        end
      end
      FUNC_LOAD: begin
        if (qc_q != '0) begin
          qc_d    = qc_q - CW'(1);
          head_d  = head_inc;
          oh_d    = queue_rd_q;
          valid_d = 1'b1;
        end else begin
          status_d = ST_EMPTY;
        end
      end
      FUNC_RELEASE: begin
        if (fc_q == CW'(MAX_BUFFERS)) begin
          status_d = ST_OVERFLOW;
        end else begin
          stack_we = 1'b1;
          fc_d     = fc_q + CW'(1);
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  assign qc_wide = SW'(qc_d);
  assign fc_wide = SW'(fc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q   <= CW'(RST_POOL);
      low_q  <= CW'(RST_POOL);
      qc_q   <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else if (cfg_we_i) begin
      fc_q   <= pool_val;
      low_q  <= pool_val;
      qc_q   <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else if (cmd_i.commit) begin
      fc_q   <= fc_d;
      low_q  <= low_d;
      qc_q   <= qc_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_e'(in_func_i);
      handle_q <= in_handle_i;
    end
    if (cmd_i.commit) begin
      out_handle_o   <= oh_d;
      handle_valid_o <= valid_d;
      took_oldest_o  <= oldest_d;
      status_o       <= status_d;
      queued_count_o <= qc_wide[CNT_OUT_W-1:0];
      free_count_o   <= fc_wide[CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && stack_we) begin
      stack_mem[fc_q[AW-1:0]] <= handle_q;
    end
    if (cmd_i.capture) begin
      stack_rd_q <= stack_mem[top_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && queue_we) begin
      queue_mem[tail_q] <= handle_q;
    end
    if (cmd_i.capture) begin
      queue_rd_q <= queue_mem[head_q];
    end
  end

endmodule

`default_nettype wire
